FILE: sv/sorted_priority_queue_unique_unit_assert.svh
// Assertion macros shared by the sorted priority queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SORTED_PRIORITY_QUEUE_UNIQUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIQUE_UNIT_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define SPQU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define SPQU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/spqu_pkg.sv
// Package for the sorted priority queue: sizes, operation and status codes,
// and the command struct broadcast to the cell row. Depends on nothing.
`default_nettype none

package spqu_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 32;
    localparam int KEY_BITS  = 16;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int OP_BITS   = 2;
    localparam int STAT_BITS = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DUP   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef struct packed {
        logic push_en;
        logic pop_en;
        t_key key;
        t_tag tag;
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: sv/spqu_cmd_if.sv
// Input channel of the sorted priority queue: valid/ready and one command item.
// Depends on spqu_pkg.
`default_nettype none

interface spqu_cmd_if
    import spqu_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_BITS-1:0]  operation;
    t_tag                name_tag;
    t_key                density_key;

    modport source (output valid, output operation, output name_tag,
                    output density_key, input ready);
    modport sink   (input valid, input operation, input name_tag,
                    input density_key, output ready);
endinterface

`default_nettype wire

FILE: sv/spqu_rsp_if.sv
// Output channel of the sorted priority queue: valid/ready and one result item.
// Depends on spqu_pkg.
`default_nettype none

interface spqu_rsp_if
    import spqu_pkg::*;
;
    logic                 valid;
    logic                 ready;
    t_tag                 result_tag;
    logic [STAT_BITS-1:0] status;
    logic                 is_empty;
    t_cnt                 entry_count;

    modport source (output valid, output result_tag, output status,
                    output is_empty, output entry_count, input ready);
    modport sink   (input valid, input result_tag, input status,
                    input is_empty, input entry_count, output ready);
endinterface

`default_nettype wire

FILE: sv/spqu_cell.sv
// One slot of the sorted row: holds a key and a tag, compares them against
// the broadcast command and shifts toward either neighbor. Depends on spqu_pkg.
`default_nettype none

module spqu_cell
    import spqu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_valid,
    input  wire logic      i_prev_le,
    input  wire t_key      i_prev_key,
    input  wire t_tag      i_prev_tag,
    input  wire t_key      i_next_key,
    input  wire t_tag      i_next_tag,
    output logic           o_le,
    output logic           o_dup,
    output t_key           o_key,
    output t_tag           o_tag
);

    t_key r_key;
    t_tag r_tag;
    t_key n_key;
    t_tag n_tag;

    assign o_le  = i_valid && (r_key <= i_cmd.key);
    assign o_dup = i_valid && (r_tag == i_cmd.tag);
    assign o_key = r_key;
    assign o_tag = r_tag;

    // A push keeps every entry whose key is not larger, drops the new item
    // into the first larger slot and moves the rest one place up.
    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_cmd.push_en && !o_le) begin
            if (i_prev_le) begin
                n_key = i_cmd.key;
                n_tag = i_cmd.tag;
            end else begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end
        end else if (i_cmd.pop_en) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

endmodule

`default_nettype wire

FILE: sv/sorted_priority_queue_unique_unit.sv
// Sorted priority queue with unique tags: control, occupancy and result register
// around a row of spqu_cell slots. Depends on spqu_pkg, spqu_cmd_if, spqu_rsp_if.
//
// Usage: commands arrive on i_cmd (push, pop smallest, peek smallest) and each
// command produces exactly one result item on o_rsp carrying the popped or
// peeked tag, a status code, the empty flag and the entry count afterwards.
// The entries live in a row of DEPTH cells kept sorted by ascending key; every
// cell compares its own entry with the command in the same cycle, so the
// duplicate check and the insert position come from one key and one tag compare
// per cell, and the whole row shifts by one place in the cycle the command is
// accepted. The result is in the output register at the edge after acceptance.
// Throughput is one item per cycle while o_rsp.ready is high; the single output
// register sets that figure. When the receiver stalls, the result waits in the
// output register and i_cmd.ready drops until it is taken. Reset empties the
// queue at once (the count goes to zero, slot contents are left as they are)
// and clears the output valid flag; no command is taken while reset is held.
`default_nettype none
`include "sorted_priority_queue_unique_unit_assert.svh"

module sorted_priority_queue_unique_unit
    import spqu_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spqu_cmd_if.sink    i_cmd,
    spqu_rsp_if.source  o_rsp
);

    t_cnt                 r_count;
    t_cnt                 n_count;
    logic                 r_out_valid;
    t_tag                 r_out_tag;
    logic [STAT_BITS-1:0] r_out_status;
    t_cnt                 r_out_count;
    t_tag                 n_out_tag;
    t_status              n_out_status;

    t_cell_cmd            cell_cmd;
    logic [DEPTH-1:0]     cell_valid;
    logic [DEPTH-1:0]     cell_le;
    logic [DEPTH-1:0]     cell_dup;
    t_key                 cell_key [DEPTH];
    t_tag                 cell_tag [DEPTH];

    logic accept;
    logic any_dup;
    logic is_full;
    logic is_empty;
    logic push_do;
    logic pop_do;
    t_op  op;

    assign i_cmd.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign op          = t_op'(i_cmd.operation);
    assign any_dup     = |cell_dup;
    assign is_full     = (r_count == CNT_BITS'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign push_do     = accept && (op == OP_PUSH) && !any_dup && !is_full;
    assign pop_do      = accept && (op == OP_POP) && !is_empty;

    assign cell_cmd.push_en = push_do;
    assign cell_cmd.pop_en  = pop_do;
    assign cell_cmd.key     = i_cmd.density_key;
    assign cell_cmd.tag     = i_cmd.name_tag;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic prev_le;
        t_key prev_key;
        t_tag prev_tag;
        t_key next_key;
        t_tag next_tag;

        if (g == 0) begin : g_first
            assign prev_le  = 1'b1;
            assign prev_key = '0;
            assign prev_tag = '0;
        end else begin : g_mid_lo
            assign prev_le  = cell_le[g-1];
            assign prev_key = cell_key[g-1];
            assign prev_tag = cell_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_key = '0;
            assign next_tag = '0;
        end else begin : g_mid_hi
            assign next_key = cell_key[g+1];
            assign next_tag = cell_tag[g+1];
        end

        assign cell_valid[g] = (CNT_BITS'(g) < r_count);

        spqu_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cell_cmd),
            .i_valid    (cell_valid[g]),
            .i_prev_le  (prev_le),
            .i_prev_key (prev_key),
            .i_prev_tag (prev_tag),
            .i_next_key (next_key),
            .i_next_tag (next_tag),
            .o_le       (cell_le[g]),
            .o_dup      (cell_dup[g]),
            .o_key      (cell_key[g]),
            .o_tag      (cell_tag[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (push_do) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (pop_do) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_comb begin
        n_out_tag    = '0;
        n_out_status = ST_OK;
        unique case (op)
            OP_PUSH: begin
                if (any_dup) begin
                    n_out_status = ST_DUP;
                end else if (is_full) begin
                    n_out_status = ST_FULL;
                end
            end
            OP_POP, OP_PEEK: begin
                if (is_empty) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_out_tag = cell_tag[0];
                end
            end
            OP_NOP: begin
                n_out_status = ST_OK;
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_tag    <= n_out_tag;
            r_out_status <= n_out_status;
            r_out_count  <= n_count;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_tag  = r_out_tag;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.is_empty    = (r_out_count == '0);

    `SPQU_ASSERT_ALWAYS(a_no_accept_in_reset, i_clk, !i_rst_n |-> !i_cmd.ready, "ready during reset")
    `SPQU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_BITS'(DEPTH), "count above depth")
    `SPQU_ASSERT(a_push_grows, i_clk, i_rst_n, push_do |=> r_count == $past(r_count) + CNT_BITS'(1), "push did not add an entry")
    `SPQU_ASSERT(a_pop_shrinks, i_clk, i_rst_n, pop_do |=> r_count == $past(r_count) - CNT_BITS'(1), "pop did not remove an entry")
    `SPQU_ASSERT(a_result_count, i_clk, i_rst_n, accept |=> o_rsp.valid && o_rsp.entry_count == r_count, "result count differs from queue count")

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for sorted_priority_queue_unique_unit: drives push, pop,
// peek and no-op items with random idling on both channels and checks every result
// against a behavioral model of the queue. Depends on spqu_pkg, spqu_cmd_if, spqu_rsp_if.
`default_nettype none

module testbench;
    import spqu_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 500000;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        t_tag    tag;
        t_status status;
        logic    is_empty;
        t_cnt    count;
    } t_queue_result;

    logic i_clk;
    logic i_rst_n;

    spqu_cmd_if cmd_bus ();
    spqu_rsp_if rsp_bus ();

    sorted_priority_queue_unique_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    t_key          model_keys [DEPTH];
    t_tag          model_tags [DEPTH];
    int            model_count = 0;
    t_queue_result expected_results [$];
    t_tag          tag_pool [POOL_SIZE];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            gap_pct = 0;
    int            stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_priority_queue_unique_unit test failed");
            $finish;
        end
    end

    // Applies one operation to the model queue and returns the result it causes.
    function automatic t_queue_result apply_to_model(t_op op, t_tag tag, t_key key);
        t_queue_result res;
        bit            held;
        int            pos;
        res.tag    = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH: begin
                held = 1'b0;
                for (int i = 0; i < model_count; i++)
                    if (model_tags[i] == tag) held = 1'b1;
                if (held) begin
                    res.status = ST_DUP;
                end else if (model_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    for (int i = 0; i < model_count; i++)
                        if (model_keys[i] <= key) pos = i + 1;
                    for (int i = model_count; i > pos; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_tags[i] = model_tags[i-1];
                    end
                    model_keys[pos] = key;
                    model_tags[pos] = tag;
                    model_count++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.tag = model_tags[0];
                    if (op == OP_POP) begin
                        for (int i = 1; i < model_count; i++) begin
                            model_keys[i-1] = model_keys[i];
                            model_tags[i-1] = model_tags[i];
                        end
                        model_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.is_empty = (model_count == 0);
        res.count    = t_cnt'(model_count);
        return res;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_cmd(t_op op, t_tag tag, t_key key);
        int gap;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) gap = pick_gap_length();
        if (gap > 0) begin
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid       = 1'b1;
        cmd_bus.operation   = op;
        cmd_bus.name_tag    = tag;
        cmd_bus.density_key = key;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        expected_results.push_back(apply_to_model(op, tag, key));
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        cmd_bus.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result item with none expected: tag=%h status=%0d count=%0d",
                         $time, rsp_bus.result_tag, rsp_bus.status, rsp_bus.entry_count);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (rsp_bus.result_tag !== want.tag) begin
                    $display("%0t: result_tag expected %h actual %h",
                             $time, want.tag, rsp_bus.result_tag);
                    fail_count++;
                end
                if (rsp_bus.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0d actual %0d",
                             $time, want.is_empty, rsp_bus.is_empty);
                    fail_count++;
                end
                if (rsp_bus.entry_count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, rsp_bus.entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int stall_left;
        stall_left    = 0;
        rsp_bus.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp_bus.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_bus.ready = 1'b1;
                if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap_length();
            end
        end
    end

    // Tags come from a small pool, now and then refreshed, so that duplicates are common.
    function automatic t_tag pick_tag();
        int idx;
        idx = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) < 10) tag_pool[idx] = $urandom;
        return tag_pool[idx];
    endfunction

    // Narrow keys give many ties; the rest span the whole range.
    function automatic t_key pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return t_key'($urandom_range(0, 3));
        if (r < 45) return '0;
        if (r < 50) return '1;
        return t_key'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic test_empty_and_full();
        t_tag fill_tags [DEPTH];
        t_key fill_keys [DEPTH];
        fill_tags = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h11, 32'h22, 32'h33, 32'h44,
                      32'h55, 32'h66, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h77, 32'h88,
                      32'h99, 32'hAA, 32'hBB, 32'hCC};
        fill_keys = '{16'h0000, 16'hFFFF, 16'h0180, 16'h0180, 16'h0100, 16'h0180,
                      16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0100, 16'h8000,
                      16'h7FFF, 16'h0001, 16'hFFFE, 16'h0180};
        gap_pct   = 20;
        stall_pct = 20;
        send_cmd(OP_POP,  32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(OP_PEEK, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(OP_NOP,  32'hFFFF_FFFF, 16'hFFFF);
        foreach (fill_tags[i]) send_cmd(OP_PUSH, fill_tags[i], fill_keys[i]);
        send_cmd(OP_PUSH, 32'hDD, 16'h0000);
        send_cmd(OP_PUSH, 32'h22, 16'h0000);
        send_cmd(OP_PEEK, 32'h0, 16'h0);
        send_cmd(OP_POP,  32'h0, 16'h0);
        send_cmd(OP_PUSH, 32'h33, 16'h1234);
        send_cmd(OP_PUSH, 32'h0000_0000, 16'h0200);
        wait_for_results();
    endtask

    task automatic test_random_traffic(int n_items, int push_pct, int gaps, int stalls);
        int r;
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                send_cmd(OP_PUSH, pick_tag(), pick_key());
            end else begin
                r = $urandom_range(0, 9);
                if (r < 6) send_cmd(OP_POP, $urandom, t_key'($urandom));
                else if (r < 9) send_cmd(OP_PEEK, $urandom, t_key'($urandom));
                else send_cmd(OP_NOP, $urandom, t_key'($urandom));
            end
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.operation   = OP_NOP;
        cmd_bus.name_tag    = '0;
        cmd_bus.density_key = '0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_full();
        test_random_traffic(300, 80, 30, 30);
        test_random_traffic(300, 20, 30, 30);
        test_random_traffic(250, 50, 0, 0);
        test_random_traffic(300, 70, 15, 40);
        test_random_traffic(300, 30, 40, 15);

        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sorted_priority_queue_unique_unit test passed");
        end else begin
            $display("sorted_priority_queue_unique_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
